// File: hw/rtl/mpsd_pkg.sv
package mpsd_pkg;

    localparam int CHANNELS_DEFAULT = 10;

    // Channels whose PID output a follower may copy.
    localparam int MASTER_LEFT  = 1;
    localparam int MASTER_RIGHT = 4;

    // The integral is kept only while the error magnitude stays inside this window.
    localparam logic signed [16:0] ERR_WINDOW = 17'sd63;

    localparam logic signed [23:0] SUM_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SUM_MIN = -24'sh800000;

    localparam logic signed [15:0] GAIN_P_RESET    = 16'sd256;
    localparam logic signed [15:0] GAIN_I_RESET    = 16'sd0;
    localparam logic signed [15:0] GAIN_D_RESET    = 16'sd0;
    localparam logic [7:0]         SLEW_STEP_RESET = 8'd10;
    localparam logic [14:0]        CEILING_RESET   = 15'd117;

    typedef enum logic [1:0] {
        OP_SPEED = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_SLEW_STEP   = 3'd3,
        REG_CEILING     = 3'd4,
        REG_FOLLOWER    = 3'd5,
        REG_LEFT_SIDE   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [7:0]         slew_step;
        logic [14:0]        output_ceiling;
        logic [10:0]        follower_mask;
        logic [10:0]        left_side_mask;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] target;
        logic signed [15:0] prev_target;
        logic signed [16:0] prev_error;
        logic signed [23:0] error_sum;
    } pid_state_t;

    typedef struct packed {
        logic               flag;
        logic signed [15:0] speed;
    } slew_state_t;

endpackage

// File: hw/rtl/multichannel_pid_slew_drive.sv
// Multichannel PID drive with slew limiting, channels 1..CHANNELS.
// Item channel (item_valid / item_stall): operation, channel, value, sensed,
// latch_target. A speed request stores the wanted speed and starts slewing;
// a PID start stores a target and enables the loop; a tick runs the loop (or
// copies master channel 1 or 4 for a follower) and then slews the channel.
// Result channel (result_valid / result_stall): out_channel and drive, one
// result per tick on a valid channel; other requests produce no result.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready
// and the user must write it only while the drive is idle; the block itself does not enforce this.
// A request accepted into the input register is processed from there into
// the result register. Throughput is one request per cycle while no tick
// waits on a stalled result; all channel state sits in flip-flops and the
// whole update of a channel is one pass from the input register to the
// result register, so back-to-back requests on the same channel see fresh state.
// Reset clears all channel state and loads the register defaults; no
// clearing sweep is needed. When result_stall holds a waiting result, the
// next tick on a valid channel waits in the input register and item_stall
// rises; all other requests still pass through.
module multichannel_pid_slew_drive
    import mpsd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  operation,
    input  logic [3:0]  channel,
    input  logic [15:0] value,
    input  logic [15:0] sensed,
    input  logic        latch_target,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [3:0]  out_channel,
    output logic [15:0] drive,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH = ((CHANNELS > MASTER_RIGHT) ? CHANNELS : MASTER_RIGHT) + 1;
    localparam int IDX_W = $clog2(DEPTH);

    cfg_t cfg;

    logic               in_valid_reg;
    logic [1:0]         op_reg;
    logic [3:0]         ch_reg;
    logic signed [15:0] value_reg;
    logic signed [15:0] sensed_reg;
    logic               latch_reg;

    logic               res_valid_reg;
    logic [3:0]         res_ch_reg;
    logic [15:0]        res_drive_reg;

    logic signed [15:0] wanted_reg    [DEPTH];
    logic signed [15:0] actual_reg    [DEPTH];
    logic               flag_reg      [DEPTH];
    logic               enabled_reg   [DEPTH];
    logic signed [15:0] target_reg    [DEPTH];
    logic signed [15:0] prev_tgt_reg  [DEPTH];
    logic signed [16:0] prev_err_reg  [DEPTH];
    logic signed [23:0] err_sum_reg   [DEPTH];
    logic signed [15:0] pid_out_reg   [DEPTH];

    logic [IDX_W-1:0]   idx;
    logic               chan_ok;
    logic               is_tick;
    logic               makes_result;
    logic               consume;
    logic               commit;
    logic               accept;
    logic               follower;
    logic               loop_active;
    logic signed [15:0] master_out;
    logic signed [15:0] new_out;
    logic signed [15:0] want_after;

    pid_state_t         pid_cur;
    pid_state_t         pid_nxt;
    logic signed [15:0] pid_calc;
    slew_state_t        slew_cur;
    slew_state_t        slew_nxt;

    mpsd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;

    assign idx          = ch_reg[IDX_W-1:0];
    assign chan_ok      = (ch_reg != 4'd0) && (ch_reg <= 4'(CHANNELS));
    assign is_tick      = (op_reg == OP_TICK);
    assign makes_result = is_tick && chan_ok;
    assign consume      = in_valid_reg && (!makes_result || !res_valid_reg || !result_stall);
    assign commit       = consume && chan_ok;
    assign item_stall   = in_valid_reg && !consume;
    assign accept       = item_valid && !item_stall;

    assign follower    = cfg.follower_mask[ch_reg];
    assign loop_active = enabled_reg[idx];
    assign master_out  = cfg.left_side_mask[ch_reg] ? pid_out_reg[MASTER_LEFT]
                                                    : pid_out_reg[MASTER_RIGHT];

    assign pid_cur.target      = target_reg[idx];
    assign pid_cur.prev_target = prev_tgt_reg[idx];
    assign pid_cur.prev_error  = prev_err_reg[idx];
    assign pid_cur.error_sum   = err_sum_reg[idx];

    mpsd_pid_math u_pid_math (
        .cur     (pid_cur),
        .sense   (sensed_reg),
        .latch   (latch_reg),
        .cfg     (cfg),
        .nxt     (pid_nxt),
        .pid_out (pid_calc)
    );

    assign new_out    = follower ? master_out : pid_calc;
    assign want_after = loop_active ? new_out : wanted_reg[idx];

    assign slew_cur.flag  = flag_reg[idx];
    assign slew_cur.speed = actual_reg[idx];

    mpsd_slew u_slew (
        .want (want_after),
        .cur  (slew_cur),
        .step (cfg.slew_step),
        .nxt  (slew_nxt)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            ch_reg     <= channel;
            value_reg  <= value;
            sensed_reg <= sensed;
            latch_reg  <= latch_target;
        end
    end

    // Channel state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                wanted_reg[i]   <= '0;
                actual_reg[i]   <= '0;
                flag_reg[i]     <= 1'b0;
                enabled_reg[i]  <= 1'b0;
                target_reg[i]   <= '0;
                prev_tgt_reg[i] <= '0;
                prev_err_reg[i] <= '0;
                err_sum_reg[i]  <= '0;
                pid_out_reg[i]  <= '0;
            end
        end
        else if (commit)
        begin
            case (op_reg)
                OP_SPEED:
                begin
                    wanted_reg[idx] <= value_reg;
                    flag_reg[idx]   <= 1'b1;
                end
                OP_START:
                begin
                    enabled_reg[idx] <= 1'b1;
                    target_reg[idx]  <= value_reg;
                end
                OP_TICK:
                begin
                    if (loop_active)
                    begin
                        pid_out_reg[idx] <= new_out;
                        wanted_reg[idx]  <= new_out;
                        if (!follower)
                        begin
                            target_reg[idx]   <= pid_nxt.target;
                            prev_tgt_reg[idx] <= pid_nxt.prev_target;
                            prev_err_reg[idx] <= pid_nxt.prev_error;
                            err_sum_reg[idx]  <= pid_nxt.error_sum;
                        end
                    end
                    actual_reg[idx] <= slew_nxt.speed;
                    flag_reg[idx]   <= slew_nxt.flag;
                end
                default:
                begin
                    flag_reg[idx] <= flag_reg[idx];
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (consume && makes_result)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && makes_result)
        begin
            res_ch_reg    <= ch_reg;
            res_drive_reg <= slew_nxt.speed;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_channel  = res_ch_reg;
    assign drive        = res_drive_reg;

endmodule

// File: hw/rtl/mpsd_cfg_regs.sv
module mpsd_cfg_regs
    import mpsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= GAIN_P_RESET;
            cfg_reg.gain_i         <= GAIN_I_RESET;
            cfg_reg.gain_d         <= GAIN_D_RESET;
            cfg_reg.slew_step      <= SLEW_STEP_RESET;
            cfg_reg.output_ceiling <= CEILING_RESET;
            cfg_reg.follower_mask  <= '0;
            cfg_reg.left_side_mask <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_GAIN_P:    cfg_reg.gain_p         <= wr_data;
                REG_GAIN_I:    cfg_reg.gain_i         <= wr_data;
                REG_GAIN_D:    cfg_reg.gain_d         <= wr_data;
                REG_SLEW_STEP: cfg_reg.slew_step      <= wr_data[7:0];
                REG_CEILING:   cfg_reg.output_ceiling <= wr_data[14:0];
                REG_FOLLOWER:  cfg_reg.follower_mask  <= wr_data[10:0];
                REG_LEFT_SIDE: cfg_reg.left_side_mask <= wr_data[10:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/mpsd_pid_math.sv
module mpsd_pid_math
    import mpsd_pkg::*;
(
    input  pid_state_t         cur,
    input  logic signed [15:0] sense,
    input  logic               latch,
    input  cfg_t               cfg,
    output pid_state_t         nxt,
    output logic signed [15:0] pid_out
);

    localparam logic signed [33:0] OUT_MIN = -34'sd32768;

    logic signed [16:0] err;
    logic signed [24:0] sum_raw;
    logic signed [23:0] sum_sat;
    logic signed [23:0] sum_new;
    logic signed [17:0] der;
    logic signed [32:0] prod_p;
    logic signed [39:0] prod_i;
    logic signed [33:0] prod_d;
    logic signed [41:0] acc;
    logic signed [33:0] scaled;
    logic signed [33:0] ceil_ext;
    logic signed [15:0] clamped;
    logic               hold;
    logic signed [15:0] target_new;

    assign err     = 17'(cur.target) - 17'(sense);
    assign sum_raw = 25'(cur.error_sum) + 25'(err);
    assign der     = 18'(err) - 18'(cur.prev_error);

    always_comb
    begin
        if (sum_raw[24] != sum_raw[23])
            sum_sat = sum_raw[24] ? SUM_MIN : SUM_MAX;
        else
            sum_sat = sum_raw[23:0];
    end

    assign sum_new = (err == 17'sd0 || err > ERR_WINDOW || err < -ERR_WINDOW)
                     ? 24'sd0 : sum_sat;

    // The three products are independent; only their sum is chained.
    assign prod_p = 33'(cfg.gain_p) * 33'(err);
    assign prod_i = 40'(cfg.gain_i) * 40'(sum_new);
    assign prod_d = 34'(cfg.gain_d) * 34'(der);
    assign acc    = 42'(prod_p) + 42'(prod_i) + 42'(prod_d);

    // Dropping the low byte of a two's complement value rounds toward minus infinity.
    assign scaled   = acc[41:8];
    assign ceil_ext = {19'b0, cfg.output_ceiling};

    always_comb
    begin
        if (scaled > ceil_ext)
            clamped = 16'(ceil_ext);
        else if (scaled < OUT_MIN)
            clamped = 16'(OUT_MIN);
        else
            clamped = scaled[15:0];
    end

    // A settled loop drives nothing and re-centers its target on the sensed position.
    assign hold = (err == 17'sd0 && cur.prev_error == 17'sd0) ||
                  (cur.target == cur.prev_target && err == cur.prev_error);

    assign target_new = hold ? sense : cur.target;

    assign nxt.target      = target_new;
    assign nxt.prev_target = latch ? target_new : cur.prev_target;
    assign nxt.prev_error  = err;
    assign nxt.error_sum   = sum_new;
    assign pid_out         = hold ? 16'sd0 : clamped;

endmodule

// File: hw/rtl/mpsd_slew.sv
module mpsd_slew
    import mpsd_pkg::*;
(
    input  logic signed [15:0] want,
    input  slew_state_t        cur,
    input  logic [7:0]         step,
    output slew_state_t        nxt
);

    logic signed [16:0] want_ext;
    logic signed [16:0] up;
    logic signed [16:0] down;

    assign want_ext = 17'(want);
    assign up       = 17'(cur.speed) + 17'(signed'({1'b0, step}));
    assign down     = 17'(cur.speed) - 17'(signed'({1'b0, step}));

    always_comb
    begin
        nxt = cur;
        if (cur.flag)
        begin
            if (want > cur.speed)
            begin
                if (up > want_ext)
                begin
                    nxt.speed = want;
                    nxt.flag  = 1'b0;
                end
                else
                begin
                    nxt.speed = up[15:0];
                end
            end
            else if (want < cur.speed)
            begin
                if (down < want_ext)
                begin
                    nxt.speed = want;
                    nxt.flag  = 1'b0;
                end
                else
                begin
                    nxt.speed = down[15:0];
                end
            end
            else
            begin
                nxt.flag = 1'b0;
            end
        end
    end

endmodule

// File: verif/testbench.sv
module testbench;
    import mpsd_pkg::*;

    localparam int CHANNELS = CHANNELS_DEFAULT;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    // Settle time after the last accepted request before a register write is sent.
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        bit                 is_cfg;
        logic [2:0]         idx;
        logic [15:0]        data;
        logic [1:0]         op;
        logic [3:0]         ch;
        logic signed [15:0] val;
        logic signed [15:0] sen;
        logic               lt;
    } request_t;

    typedef struct {
        logic [3:0]  ch;
        logic [15:0] drv;
    } drive_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  operation = '0;
    logic [3:0]  channel = '0;
    logic [15:0] value = '0;
    logic [15:0] sensed = '0;
    logic        latch_target = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [3:0]  out_channel;
    logic [15:0] drive;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    multichannel_pid_slew_drive #(.CHANNELS(CHANNELS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .operation(operation),
        .channel(channel),
        .value(value),
        .sensed(sensed),
        .latch_target(latch_target),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .out_channel(out_channel),
        .drive(drive),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predicted drive state, one entry per channel number.
    cfg_t               regs;
    logic signed [15:0] want_spd [0:10];
    logic signed [15:0] act_spd [0:10];
    logic               slewing [0:10];
    logic               loop_on [0:10];
    logic signed [15:0] tgt [0:10];
    logic signed [15:0] last_tgt [0:10];
    logic signed [16:0] last_err [0:10];
    logic signed [23:0] err_acc [0:10];
    logic signed [15:0] loop_out [0:10];

    request_t      pending [$];
    drive_result_t drive_expected [$];
    int            target_hint [0:15];

    request_t req;
    logic     nxt_item;
    logic     nxt_cfg;
    logic     item_fire = 1'b0;
    logic     cfg_fire = 1'b0;
    logic     result_fire = 1'b0;
    int       send_gap = 0;
    int       stall_left = 0;
    bit       calm_in = 1'b0;
    bit       calm_out = 1'b0;
    int       settle = 0;
    int       quiet = 0;
    int       mismatches = 0;
    int       items_taken = 0;
    int       ticks_checked = 0;
    int       cfg_writes = 0;
    int       settings = 1;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic push_item(input logic [1:0] op, input logic [3:0] ch,
                             input logic signed [15:0] val, input logic signed [15:0] sen,
                             input logic lt);
        request_t r;
        r = '{default: '0};
        r.op = op;
        r.ch = ch;
        r.val = val;
        r.sen = sen;
        r.lt = lt;
        pending.push_back(r);
    endtask

    task automatic push_cfg(input logic [2:0] idx, input logic [15:0] data);
        request_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        pending.push_back(r);
    endtask

    task automatic program_registers(input int gp, input int gi, input int gd,
                                     input int slew, input int ceil,
                                     input int fmask, input int lmask);
        push_cfg(REG_GAIN_P, gp[15:0]);
        push_cfg(REG_GAIN_I, gi[15:0]);
        push_cfg(REG_GAIN_D, gd[15:0]);
        push_cfg(REG_SLEW_STEP, slew[15:0]);
        push_cfg(REG_CEILING, ceil[15:0]);
        push_cfg(REG_FOLLOWER, fmask[15:0]);
        push_cfg(REG_LEFT_SIDE, lmask[15:0]);
    endtask

    task automatic random_phase(input int count);
        int tmp;
        logic [1:0] op;
        logic [3:0] ch;
        logic signed [15:0] val;
        logic signed [15:0] sen;
        logic lt;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 94)
                tmp = $urandom_range(1, CHANNELS);
            else
            begin
                tmp = $urandom_range(0, 5);
                if (tmp != 0)
                    tmp = 10 + tmp;
            end
            ch = tmp[3:0];
            tmp = $urandom_range(0, 99);
            if (tmp < 22)
                op = OP_SPEED;
            else if (tmp < 42)
                op = OP_START;
            else if (tmp < 97)
                op = OP_TICK;
            else
                op = OP_UNUSED;
            val = 16'($urandom());
            sen = 16'($urandom());
            lt = 1'($urandom_range(0, 1));
            if (op == OP_SPEED && $urandom_range(0, 1) == 0)
            begin
                tmp = $urandom_range(0, 400) - 200;
                val = tmp[15:0];
            end
            if (op == OP_START)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    tmp = $urandom_range(0, 4000) - 2000;
                    val = tmp[15:0];
                end
                target_hint[ch] = val;
            end
            // Most ticks sense close to the target so the integral window is hit.
            if (op == OP_TICK)
            begin
                tmp = $urandom_range(0, 99);
                if (tmp < 10)
                    tmp = target_hint[ch];
                else if (tmp < 75)
                    tmp = target_hint[ch] + $urandom_range(0, 140) - 70;
                else
                    tmp = $urandom();
                sen = tmp[15:0];
            end
            push_item(op, ch, val, sen, lt);
        end
    endtask

    task automatic apply_register(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            REG_GAIN_P:    regs.gain_p = data;
            REG_GAIN_I:    regs.gain_i = data;
            REG_GAIN_D:    regs.gain_d = data;
            REG_SLEW_STEP: regs.slew_step = data[7:0];
            REG_CEILING:   regs.output_ceiling = data[14:0];
            REG_FOLLOWER:  regs.follower_mask = data[10:0];
            REG_LEFT_SIDE: regs.left_side_mask = data[10:0];
            default: ;
        endcase
    endtask

    task automatic predict_drive(input request_t r);
        int c;
        int err;
        int sum;
        int der;
        int mag;
        int now;
        int want;
        longint acc;
        drive_result_t res;
        c = r.ch;
        if (c < 1 || c > CHANNELS)
            return;
        case (r.op)
            OP_SPEED:
            begin
                want_spd[c] = r.val;
                slewing[c] = 1'b1;
            end
            OP_START:
            begin
                loop_on[c] = 1'b1;
                tgt[c] = r.val;
            end
            OP_TICK:
            begin
                if (loop_on[c])
                begin
                    if (regs.follower_mask[c])
                        loop_out[c] = regs.left_side_mask[c] ? loop_out[MASTER_LEFT]
                                                             : loop_out[MASTER_RIGHT];
                    else
                    begin
                        err = int'(tgt[c]) - int'(r.sen);
                        sum = int'(err_acc[c]) + err;
                        der = err - int'(last_err[c]);
                        mag = err < 0 ? -err : err;
                        if (sum > int'(SUM_MAX))
                            sum = int'(SUM_MAX);
                        if (sum < int'(SUM_MIN))
                            sum = int'(SUM_MIN);
                        if (err == 0 || mag > int'(ERR_WINDOW))
                            sum = 0;
                        err_acc[c] = sum[23:0];
                        acc = longint'($signed(regs.gain_p)) * err
                            + longint'($signed(regs.gain_i)) * sum
                            + longint'($signed(regs.gain_d)) * der;
                        acc = acc >>> 8;
                        if (acc > longint'(regs.output_ceiling))
                            acc = longint'(regs.output_ceiling);
                        if (acc < -32768)
                            acc = -32768;
                        // Stop detection: the loop has nothing to do, so hold here.
                        if ((err == 0 && last_err[c] == 0) ||
                            (tgt[c] == last_tgt[c] && err == int'(last_err[c])))
                        begin
                            acc = 0;
                            tgt[c] = r.sen;
                        end
                        last_err[c] = err[16:0];
                        if (r.lt)
                            last_tgt[c] = tgt[c];
                        loop_out[c] = acc[15:0];
                    end
                    want_spd[c] = loop_out[c];
                end
                if (slewing[c])
                begin
                    want = want_spd[c];
                    now = act_spd[c];
                    if (want > now)
                    begin
                        now = now + int'(regs.slew_step);
                        if (now > want)
                        begin
                            now = want;
                            slewing[c] = 1'b0;
                        end
                    end
                    else if (want < now)
                    begin
                        now = now - int'(regs.slew_step);
                        if (now < want)
                        begin
                            now = want;
                            slewing[c] = 1'b0;
                        end
                    end
                    else
                        slewing[c] = 1'b0;
                    act_spd[c] = now[15:0];
                end
                res.ch = r.ch;
                res.drv = act_spd[c];
                drive_expected.push_back(res);
            end
            default: ;
        endcase
    endtask

    // Request driver: a register write waits until the drive has gone quiet.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_fire)
            begin
            end
            else if (cfg_valid && !cfg_fire)
            begin
            end
            else
            begin
                nxt_item = 1'b0;
                nxt_cfg = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (pending.size() > 0)
                begin
                    if (pending[0].is_cfg)
                    begin
                        if (drive_expected.size() == 0 && settle >= SETTLE_CYCLES)
                        begin
                            req = pending.pop_front();
                            cfg_index <= req.idx;
                            cfg_data <= req.data;
                            nxt_cfg = 1'b1;
                        end
                    end
                    else
                    begin
                        req = pending.pop_front();
                        operation <= req.op;
                        channel <= req.ch;
                        value <= req.val;
                        sensed <= req.sen;
                        latch_target <= req.lt;
                        nxt_item = 1'b1;
                        if ($urandom_range(0, 39) == 0)
                            calm_in = !calm_in;
                        send_gap = calm_in ? 0 : $urandom_range(0, 19);
                    end
                end
                item_valid <= nxt_item;
                cfg_valid <= nxt_cfg;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_fire)
            begin
                if ($urandom_range(0, 39) == 0)
                    calm_out = !calm_out;
                stall_left = calm_out ? 0 : $urandom_range(0, 19);
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        drive_result_t exp_res;
        request_t taken;
        if (rst_n)
        begin
            item_fire <= item_valid && !item_stall;
            cfg_fire <= cfg_valid && cfg_ready;
            result_fire <= result_valid && !result_stall;
            if (result_valid && !result_stall)
            begin
                if (drive_expected.size() == 0)
                    report_mismatch("result with nothing expected", out_channel, 0);
                else
                begin
                    exp_res = drive_expected.pop_front();
                    if (out_channel !== exp_res.ch)
                        report_mismatch("out_channel", out_channel, exp_res.ch);
                    if (drive !== exp_res.drv)
                        report_mismatch("drive", drive, exp_res.drv);
                    ticks_checked++;
                end
            end
            if (item_valid && !item_stall)
            begin
                taken = '{default: '0};
                taken.op = operation;
                taken.ch = channel;
                taken.val = value;
                taken.sen = sensed;
                taken.lt = latch_target;
                predict_drive(taken);
                items_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_register(cfg_index, cfg_data);
                cfg_writes++;
            end
            if ((item_valid && !item_stall) || drive_expected.size() != 0)
                settle <= 0;
            else if (settle < 255)
                settle <= settle + 1;
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        regs.gain_p = GAIN_P_RESET;
        regs.gain_i = GAIN_I_RESET;
        regs.gain_d = GAIN_D_RESET;
        regs.slew_step = SLEW_STEP_RESET;
        regs.output_ceiling = CEILING_RESET;
        regs.follower_mask = '0;
        regs.left_side_mask = '0;
        for (int c = 0; c <= 10; c++)
        begin
            want_spd[c] = '0;
            act_spd[c] = '0;
            slewing[c] = 1'b0;
            loop_on[c] = 1'b0;
            tgt[c] = '0;
            last_tgt[c] = '0;
            last_err[c] = '0;
            err_acc[c] = '0;
            loop_out[c] = '0;
        end
        for (int c = 0; c < 16; c++)
            target_hint[c] = 0;

        // Directed requests at the reset register values.
        push_item(OP_SPEED, 4'd1, 16'sh7FFF, 16'sh0000, 1'b0);
        push_item(OP_TICK, 4'd1, 16'sh0000, 16'sh0000, 1'b0);
        push_item(OP_SPEED, 4'd2, 16'sh8000, 16'shFFFF, 1'b1);
        push_item(OP_TICK, 4'd2, 16'shFFFF, 16'sh8000, 1'b0);
        push_item(OP_TICK, 4'd3, 16'sh1234, 16'sh7FFF, 1'b1);
        push_item(OP_UNUSED, 4'd3, 16'sh7FFF, 16'sh7FFF, 1'b1);
        push_item(OP_TICK, 4'd0, 16'sh0000, 16'sh0000, 1'b0);
        push_item(OP_SPEED, 4'd0, 16'sh0100, 16'sh0000, 1'b0);
        push_item(OP_TICK, 4'd11, 16'sh0000, 16'sh0000, 1'b0);
        push_item(OP_START, 4'd15, 16'sh0050, 16'sh0000, 1'b1);
        push_item(OP_START, 4'd1, 16'sd100, 16'sh0000, 1'b0);
        push_item(OP_TICK, 4'd1, 16'sh0000, 16'sd90, 1'b1);
        push_item(OP_TICK, 4'd1, 16'sh0000, 16'sd100, 1'b0);
        push_item(OP_TICK, 4'd1, 16'sh0000, 16'sd100, 1'b1);
        push_item(OP_START, 4'd4, 16'sh8000, 16'sh0000, 1'b0);
        push_item(OP_TICK, 4'd4, 16'sh0000, 16'sh7FFF, 1'b0);
        push_item(OP_TICK, 4'd4, 16'sh0000, 16'sh8000, 1'b1);
        push_item(OP_START, 4'd10, 16'sh7FFF, 16'sh0000, 1'b0);
        push_item(OP_TICK, 4'd10, 16'sh0000, 16'sh8000, 1'b0);
        push_item(OP_SPEED, 4'd10, 16'sh0000, 16'sh0000, 1'b0);
        push_item(OP_TICK, 4'd10, 16'sh0000, 16'sh8000, 1'b1);
        push_item(OP_SPEED, 4'd5, 16'sd5, 16'sh0000, 1'b0);
        push_item(OP_TICK, 4'd5, 16'sh0000, 16'sh0000, 1'b0);
        push_item(OP_TICK, 4'd5, 16'sh0000, 16'sh0000, 1'b0);

        program_registers(32767, 32767, 32767, 255, 32767, 16'hFFFF, 16'hFFFF);
        random_phase(110);
        // A slew step of zero freezes every slewing channel.
        program_registers(-32768, -32768, -32768, 0, 0, 0, 0);
        push_cfg(REG_UNUSED, 16'($urandom()));
        random_phase(110);
        for (int p = 0; p < 5; p++)
        begin
            program_registers($urandom_range(0, 1023) - 512, $urandom_range(0, 255) - 128,
                              $urandom_range(0, 511) - 256, $urandom_range(1, 255),
                              $urandom_range(0, 32767), $urandom(), $urandom());
            random_phase(130);
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || item_valid || cfg_valid || drive_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d accepted requests and %0d checked drive results,",
                 items_taken, ticks_checked);
        $display("with %0d register writes across %0d register settings.", cfg_writes, settings + 7);
        if (mismatches == 0 && drive_expected.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: multichannel_pid_slew_drive.f
hw/rtl/mpsd_pkg.sv
hw/rtl/mpsd_cfg_regs.sv
hw/rtl/mpsd_pid_math.sv
hw/rtl/mpsd_slew.sv
hw/rtl/multichannel_pid_slew_drive.sv
verif/testbench.sv
